@@ design/pdd_pkg.sv @@
// ----------------------------------------------------------------------------
// Proximity dwell detector package
// Shared types and constants: beat payloads, register indexes, field widths.
// ----------------------------------------------------------------------------
package pdd_pkg;

  localparam int unsigned DIST_W     = 13;
  localparam int unsigned DWELL_W    = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Every window slot reads as this range until a sample overwrites it.
  localparam logic [DIST_W-1:0] SLOT_RESET = 13'd180;

  localparam logic [DIST_W-1:0]  NEAR_THR_RESET   = 13'd150;
  localparam logic [DWELL_W-1:0] SHORT_DWELL_RESET = 16'd1000;
  localparam logic [DWELL_W-1:0] LONG_DWELL_RESET  = 16'd3000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEAR_THRESHOLD = 2'd0,
    REG_SHORT_DWELL    = 2'd1,
    REG_LONG_DWELL     = 2'd2
  } pdd_reg_e;

  typedef struct packed {
    logic [DIST_W-1:0] distance_mm;
    logic              out_of_range;
    logic              servo_busy;
    logic [TIME_W-1:0] now_ms;
  } pdd_in_t;

  typedef struct packed {
    logic              hand_near;
    logic              short_attn;
    logic              long_attn;
    logic [DIST_W-1:0] average_mm;
  } pdd_out_t;

endpackage

@@ design/proximity_dwell_detector.sv @@
// ----------------------------------------------------------------------------
// Proximity dwell detector
// Moving-average near detection over a range window with dwell-timed events.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                         Direction  Beat contents
//  -------   ------------------------------  ---------  ----------------------
//  in        in_valid_i, in_stall_o,         sink       one range sample
//            in_data_i
//  out       out_valid_o, out_stall_i,       source     near flag, events and
//            out_data_o                                 window average
//  cfg       cfg_we_i, cfg_idx_i,            sink       one register write
//            cfg_wdata_i
//
// Every sample beat produces exactly one result beat via the input register and
// then the result register. A new sample can be taken in every cycle unless
// the input side is stalled; the rate is one beat per cycle, set by the single
// update of the running sum and the near/dwell state in the compute stage.
// Reset clears the window to 180 mm per slot, the flags and the timestamp, and
// loads the register defaults. A stall on the output holds the result
// register; the input register still takes one more beat before the input
// side is stalled in turn.
//
// The design has two register stages. The input register captures the
// sample. Between it and the result register, the window unit adds the new
// range and drops the oldest one, a compare against threshold times window
// size decides whether the object is near, and the dwell since the start of
// the approach is compared against both dwell registers. The near flag, the
// long-event latch and the approach timestamp update when the sample moves
// into the result register, so back-to-back samples see each other's effect.

module proximity_dwell_detector import pdd_pkg::*; #(
  parameter int unsigned WINDOW = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pdd_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pdd_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned SumW = DIST_W + $clog2(WINDOW);

  // Configuration registers.
  logic [DIST_W-1:0]  near_thr_q;
  logic [DWELL_W-1:0] short_dwell_q;
  logic [DWELL_W-1:0] long_dwell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_thr_q    <= NEAR_THR_RESET;
      short_dwell_q <= SHORT_DWELL_RESET;
      long_dwell_q  <= LONG_DWELL_RESET;
    end else if (cfg_we_i) begin
      case (pdd_reg_e'(cfg_idx_i))
        REG_NEAR_THRESHOLD: near_thr_q    <= cfg_wdata_i[DIST_W-1:0];
        REG_SHORT_DWELL:    short_dwell_q <= cfg_wdata_i[DWELL_W-1:0];
        REG_LONG_DWELL:     long_dwell_q  <= cfg_wdata_i[DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake. The compute stage advances whenever the result
  // register is empty or its beat is being taken.
  logic    s1_valid_q;
  pdd_in_t s1_data_q;
  logic    out_valid_q;
  pdd_out_t out_data_q;
  logic    advance;
  logic    fire;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
  end

  // Window sum and average for the sample in the compute stage.
  logic [SumW-1:0]   sum_next;
  logic [DIST_W-1:0] avg_next;

  pdd_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .shift_i(fire),
    .dist_i (s1_data_q.distance_mm),
    .sum_o  (sum_next),
    .avg_o  (avg_next)
  );

  // Near decision and dwell timing.
  logic              near_q, near_d;
  logic              long_fired_q, long_fired_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic [SumW-1:0]   thr_scaled;
  logic [TIME_W-1:0] dwell;
  logic              near_now;
  logic              short_ev;
  logic              long_ev;

  // Comparing the sum against threshold times window size is the same as
  // comparing the exact average against the threshold.
  assign thr_scaled = SumW'(near_thr_q) * SumW'(WINDOW);
  assign near_now   = (sum_next < thr_scaled) && !s1_data_q.out_of_range;
  // Wrapping subtraction keeps the dwell right across timestamp rollover.
  assign dwell      = s1_data_q.now_ms - start_q;

  always_comb begin
    near_d       = near_q;
    long_fired_d = long_fired_q;
    start_d      = start_q;
    short_ev     = 1'b0;
    long_ev      = 1'b0;
    if (!near_now) begin
      // Departure ends the approach and re-arms the long event.
      near_d       = 1'b0;
      long_fired_d = 1'b0;
    end else if (!near_q) begin
      // The first near sample only starts the approach, no event yet.
      near_d  = 1'b1;
      start_d = s1_data_q.now_ms;
    end else if (!s1_data_q.servo_busy && !long_fired_q) begin
      short_ev = dwell >= TIME_W'(short_dwell_q);
      long_ev  = dwell >= TIME_W'(long_dwell_q);
      if (long_ev) begin
        long_fired_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q       <= 1'b0;
      long_fired_q <= 1'b0;
      start_q      <= '0;
    end else if (fire) begin
      near_q       <= near_d;
      long_fired_q <= long_fired_d;
      start_q      <= start_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q.hand_near  <= near_d;
      out_data_q.short_attn <= short_ev;
      out_data_q.long_attn  <= long_ev;
      out_data_q.average_mm <= avg_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The long-event latch is only ever set during an approach.
  a_latch_needs_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_fired_q |-> near_q)
    else $error("long event latch set while not near");

  // An event is only reported on a sample that keeps the object near.
  a_event_needs_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.short_attn || out_data_o.long_attn))
      |-> out_data_o.hand_near)
    else $error("attention event reported without near flag");

  // The input side is only stalled when both stages are full and blocked.
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // A far sample during an approach ends it and clears the latch.
  a_departure_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && near_q && !near_now) |=> (!near_q && !long_fired_q))
    else $error("departure did not clear approach state");

  // A long event latches, so it cannot fire again in the same approach.
  a_long_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && long_ev) |=> long_fired_q)
    else $error("long event did not set its latch");

endmodule

@@ design/pdd_window.sv @@
// ----------------------------------------------------------------------------
// Proximity dwell detector sample window
// Shift line of the last WINDOW ranges, running sum and truncated average.
// ----------------------------------------------------------------------------
module pdd_window import pdd_pkg::*; #(
  parameter int unsigned WINDOW = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                shift_i,
  input  logic [DIST_W-1:0]                   dist_i,
  output logic [DIST_W+$clog2(WINDOW)-1:0]    sum_o,
  output logic [DIST_W-1:0]                   avg_o
);

  localparam int unsigned SumW  = DIST_W + $clog2(WINDOW);
  localparam int unsigned Log2W = $clog2(WINDOW);
  localparam int unsigned Shift = SumW + Log2W;
  localparam int unsigned RecW  = SumW + 1;
  // Rounded-up reciprocal: floor(x * Recip / 2^Shift) equals floor(x / WINDOW)
  // for every x below 2^SumW.
  localparam longint unsigned RecipL = ((64'd1 << Shift) + WINDOW - 1) / WINDOW;
  localparam logic [RecW-1:0] Recip  = RecW'(RecipL);
  localparam logic [SumW-1:0] SumReset = SumW'(SLOT_RESET * WINDOW);

  logic [DIST_W-1:0]      win_q [WINDOW];
  logic [SumW-1:0]        sum_q;
  logic [SumW-1:0]        sum_d;
  logic [SumW+RecW-1:0]   prod;

  // The oldest sample sits at the far end of the shift line.
  assign sum_d = sum_q - SumW'(win_q[WINDOW-1]) + SumW'(dist_i);
  assign prod  = (SumW+RecW)'(sum_d) * (SumW+RecW)'(Recip);

  assign sum_o = sum_d;
  assign avg_o = prod[Shift +: DIST_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_q[i] <= SLOT_RESET;
      end
      sum_q <= SumReset;
    end else if (shift_i) begin
      win_q[0] <= dist_i;
      for (int i = 1; i < WINDOW; i++) begin
        win_q[i] <= win_q[i-1];
      end
      sum_q <= sum_d;
    end
  end

endmodule
